// ===== rtl/kfrp_pkg.sv =====
// Shared types, codes and constant tables for the font ROM port.
package kfrp_pkg;

  // ROM geometry
  localparam int ROM_BYTES = 131072;
  localparam int ROM_AW    = 17;

  // Transaction kinds
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MACHINE_VERSION = 1'b0;
  localparam logic CFG_AS_IS_MODE      = 1'b1;

  // Bus port addresses
  localparam logic [15:0] PORT_ADDR_HI  = 16'hfd20;
  localparam logic [15:0] PORT_ADDR_LO  = 16'hfd21;
  localparam logic [15:0] PORT_L1_EVEN  = 16'hfd22;
  localparam logic [15:0] PORT_L1_ODD   = 16'hfd23;
  localparam logic [15:0] PORT_ADDR2_HI = 16'hfd2c;
  localparam logic [15:0] PORT_ADDR2_LO = 16'hfd2d;
  localparam logic [15:0] PORT_L2_EVEN  = 16'hfd2e;
  localparam logic [15:0] PORT_L2_ODD   = 16'hfd2f;

  // Level-1 area limits (byte offsets)
  localparam logic [ROM_AW-1:0] LEGACY_LOW_END = 17'h06000;
  localparam logic [ROM_AW-1:0] UNDEF_END      = 17'h08000;

  // Result byte source
  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_L1    = 2'd1;
  localparam logic [1:0] SRC_L2    = 2'd2;

  // Bitmap of glyphs that read as 00/01 in the legacy view
  localparam int UNDEF_WORDS = 24;
  localparam logic [31:0] UNDEF_MAP [UNDEF_WORDS] = '{
    32'hffffffff, 32'h00000001, 32'hffff8001, 32'hfc00ffff,
    32'h00000001, 32'h00000001, 32'hfe000001, 32'h00000001,
    32'hffffffff, 32'h80000000, 32'hffffffff, 32'hf8000001,
    32'hfff00000, 32'hff800000, 32'hffffffff, 32'hfffc0000,
    32'hffffffff, 32'h00000000, 32'hffffffff, 32'hf8000001,
    32'h00000000, 32'h00000000, 32'hfe000001, 32'h0001fffc
  };

  // Swapped glyphs: level-1 glyph word address and its level-2 source
  localparam int SWAP_COUNT = 25;
  localparam logic [15:0] SWAP_GLYPH [SWAP_COUNT] = '{
    16'h4130, 16'h4490, 16'h6620, 16'h6690, 16'h8760, 16'h6830, 16'h6920,
    16'h6FB0, 16'h73C0, 16'h7890, 16'h7F90, 16'hA280, 16'hC9B0, 16'hCB70,
    16'hEAE0, 16'hEB30, 16'hED60, 16'hEE80, 16'hB300, 16'hF790, 16'hF990,
    16'hBF60, 16'h6C60, 16'hF6A0, 16'hDBA0
  };
  localparam logic [15:0] SWAP_SRC [SWAP_COUNT] = '{
    16'hE4D0, 16'hD540, 16'h93A0, 16'h5380, 16'h87E0, 16'h5D50, 16'h97D0,
    16'hD140, 16'hA480, 16'h7220, 16'hE170, 16'h98D0, 16'h4840, 16'hA4A0,
    16'h56D0, 16'h1D90, 16'hBAE0, 16'h7440, 16'h3780, 16'h2160, 16'h72E0,
    16'h8860, 16'hC810, 16'hC820, 16'hC830
  };

  // Legacy view lookup result for one level-1 byte offset
  typedef struct packed {
    logic              bitmap_hit;
    logic              swap_hit;
    logic [ROM_AW-1:0] l2_addr;
  } legacy_t;

endpackage

// ===== rtl/kfrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kfrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kfrp_legacy.sv =====
// Legacy glyph view lookup: undefined-glyph bitmap and swapped-glyph redirect.
module kfrp_legacy (
  input  logic [kfrp_pkg::ROM_AW-1:0] off,
  output kfrp_pkg::legacy_t           view
);
  import kfrp_pkg::*;

  logic [4:0] word_idx;
  logic [4:0] bit_idx;
  logic [31:0] map_word;

  // Bitmap: word from offset bits 14..10 (low area only), bit from bits 9..5
  assign word_idx = off[14:10];
  assign bit_idx  = off[9:5];
  assign map_word = UNDEF_MAP[word_idx];

  always_comb begin
    view.bitmap_hit = (off < LEGACY_LOW_END) && map_word[bit_idx];
    view.swap_hit   = 1'b0;
    view.l2_addr    = off;
    // Each swapped glyph covers 32 aligned bytes: match on offset bits 16..5
    for (int k = SWAP_COUNT - 1; k >= 0; k--) begin
      if (off[ROM_AW-1:5] == SWAP_GLYPH[k][15:4]) begin
        view.swap_hit = 1'b1;
        view.l2_addr  = {SWAP_SRC[k], 1'b0} + {12'd0, off[4:0]};
      end
    end
  end

endmodule

// ===== rtl/kanji_font_rom_port.sv =====
// Top level of the font ROM port: decode, glyph/bank registers, ROMs, result stage.
//
// Takes one transaction per clock (busy is always low) and returns exactly one
// result per transaction, strobe high for one cycle, after the registered ROM
// read and then the result register.
// Results come back in order and cannot be held off. Address and bank writes
// take effect for the next transaction. ROM bytes are loaded through the same
// command port; the ROMs are not cleared by reset and read as garbage until
// loaded.
module kanji_font_rom_port (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [15:0]                 bus_addr,
  input  logic [7:0]                  write_data,
  input  logic                        rom_select,
  input  logic [kfrp_pkg::ROM_AW-1:0] rom_byte_addr,
  input  logic                        sub_kanji_owned,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [2:0]                  cfg_data,
  output logic                        strobe,
  output logic [7:0]                  read_data,
  output logic                        handled,
  output logic                        dict_ram_enable,
  output logic                        dict_rom_enable,
  output logic [5:0]                  dict_rom_bank
);
  import kfrp_pkg::*;

  // Configuration
  logic [2:0] machine_version;
  logic       as_is_mode;

  // Port state
  logic [15:0] glyph_address;
  logic        dict_ram_on;
  logic        dict_rom_on;
  logic [5:0]  dict_bank;
  logic [15:0] glyph_address_next;
  logic        dict_ram_on_next;
  logic        dict_rom_on_next;
  logic [5:0]  dict_bank_next;

  // Decode stage
  logic              accept;
  logic              newer;
  logic              legacy_mode;
  logic [ROM_AW-1:0] off;
  legacy_t           view;
  logic              hit;
  logic [1:0]        src;
  logic [7:0]        cval;
  logic [ROM_AW-1:0] l2_raddr;
  logic              l1_we;
  logic              l2_we;
  logic [7:0]        l1_rdata;
  logic [7:0]        l2_rdata;

  // ROM read stage
  logic       s1_valid;
  logic [1:0] s1_src;
  logic [7:0] s1_cval;
  logic       s1_hit;
  logic       s1_dict_ram;
  logic       s1_dict_rom;
  logic [5:0] s1_bank;
  logic [7:0] s1_byte;

  assign busy        = 1'b0;
  assign accept      = start;
  assign newer       = machine_version >= 3'd3;
  assign legacy_mode = (machine_version <= 3'd2) && !as_is_mode;
  assign off         = {glyph_address, bus_addr[0]};

  kfrp_legacy u_legacy (
    .off  (off),
    .view (view)
  );

  // Read path decode: pick a constant byte or a ROM and its address; also flag port writes
  always_comb begin
    hit      = 1'b0;
    src      = SRC_CONST;
    cval     = 8'h00;
    l2_raddr = off;
    if (action == ACT_READ) begin
      case (bus_addr)
        PORT_ADDR_HI, PORT_ADDR_LO, PORT_ADDR2_HI, PORT_ADDR2_LO: begin
          hit  = 1'b1;
          cval = 8'hff;
        end
        PORT_L1_EVEN, PORT_L1_ODD: begin
          hit = 1'b1;
          if (sub_kanji_owned) begin
            cval = 8'hff;
          end else if (!legacy_mode) begin
            src = SRC_L1;
          end else if ((off >= LEGACY_LOW_END) && (machine_version <= 3'd1) &&
                       (off < UNDEF_END)) begin
            // undefined area on the oldest machines
            cval = {7'd0, bus_addr[0]};
          end else if (view.bitmap_hit) begin
            cval = {7'd0, off[0]};
          end else if (view.swap_hit) begin
            src      = SRC_L2;
            l2_raddr = view.l2_addr;
          end else begin
            src = SRC_L1;
          end
        end
        PORT_L2_EVEN, PORT_L2_ODD: begin
          hit = 1'b1;
          if (!newer || sub_kanji_owned) begin
            cval = 8'hff;
          end else begin
            src = SRC_L2;
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end else if (action == ACT_WRITE) begin
      case (bus_addr)
        PORT_ADDR_HI, PORT_ADDR_LO, PORT_ADDR2_HI, PORT_ADDR2_LO,
        PORT_L1_EVEN, PORT_L1_ODD, PORT_L2_EVEN, PORT_L2_ODD: begin
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  // Write path: glyph address and dictionary bank register
  always_comb begin
    glyph_address_next = glyph_address;
    dict_ram_on_next   = dict_ram_on;
    dict_rom_on_next   = dict_rom_on;
    dict_bank_next     = dict_bank;
    if (action == ACT_WRITE) begin
      case (bus_addr)
        PORT_ADDR_HI: begin
          glyph_address_next[15:8] = write_data;
        end
        PORT_ADDR_LO: begin
          glyph_address_next[7:0] = write_data;
        end
        PORT_ADDR2_HI: begin
          if (newer) begin
            glyph_address_next[15:8] = write_data;
          end
        end
        PORT_ADDR2_LO: begin
          if (newer) begin
            glyph_address_next[7:0] = write_data;
          end
        end
        PORT_L2_EVEN: begin
          if (newer) begin
            dict_ram_on_next = write_data[7];
            dict_rom_on_next = write_data[6];
            dict_bank_next   = write_data[5:0];
          end
        end
        default: begin
          glyph_address_next = glyph_address;
        end
      endcase
    end
  end

  // ROM loads
  assign l1_we = accept && (action == ACT_LOAD) && !rom_select;
  assign l2_we = accept && (action == ACT_LOAD) && rom_select;

  kfrp_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_level_one_rom (
    .clk   (clk),
    .we    (l1_we),
    .waddr (rom_byte_addr),
    .wdata (write_data),
    .raddr (off),
    .rdata (l1_rdata)
  );

  kfrp_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_level_two_rom (
    .clk   (clk),
    .we    (l2_we),
    .waddr (rom_byte_addr),
    .wdata (write_data),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  // Control state, configuration and strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      machine_version <= 3'd3;
      as_is_mode      <= 1'b0;
      glyph_address   <= 16'h0000;
      dict_ram_on     <= 1'b0;
      dict_rom_on     <= 1'b0;
      dict_bank       <= 6'd0;
      s1_valid        <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MACHINE_VERSION: machine_version <= cfg_data;
          default:             as_is_mode      <= cfg_data[0];
        endcase
      end
      if (accept) begin
        glyph_address <= glyph_address_next;
        dict_ram_on   <= dict_ram_on_next;
        dict_rom_on   <= dict_rom_on_next;
        dict_bank     <= dict_bank_next;
      end
      s1_valid <= accept;
      strobe   <= s1_valid;
    end
  end

  // Payload alongside the ROM read; bank fields as left by this transaction
  always_ff @(posedge clk) begin
    s1_src      <= src;
    s1_cval     <= cval;
    s1_hit      <= hit;
    s1_dict_ram <= dict_ram_on_next;
    s1_dict_rom <= dict_rom_on_next;
    s1_bank     <= dict_bank_next;
  end

  // Result byte select
  always_comb begin
    case (s1_src)
      SRC_L1:  s1_byte = l1_rdata;
      SRC_L2:  s1_byte = l2_rdata;
      default: s1_byte = s1_cval;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    read_data       <= s1_byte;
    handled         <= s1_hit;
    dict_ram_enable <= s1_dict_ram;
    dict_rom_enable <= s1_dict_rom;
    dict_rom_bank   <= s1_bank;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the font ROM port: predicts every result and checks it in order.
`timescale 1ns / 1ps

module testbench;
  import kfrp_pkg::*;

  // action 3 is unused by the block and must change nothing
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam logic [2:0] PHASE_VERSION [PHASES] = '{
    3'd3, 3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd2, 3'd0, 3'd5, 3'd1, 3'd3, 3'd6
  };
  localparam logic       PHASE_AS_IS   [PHASES] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };
  localparam logic [15:0] DATA_PORTS [4] = '{PORT_L1_EVEN, PORT_L1_ODD, PORT_L2_EVEN, PORT_L2_ODD};

  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
    logic       ram_en;
    logic       rom_en;
    logic [5:0] bank;
  } port_reply_t;

  // Behavioral copy of the port: glyph/bank registers, loaded ROM bytes, pending replies
  class font_port_model;
    logic [2:0]  version;
    logic        as_is;
    logic [15:0] glyph;
    logic        ram_on;
    logic        rom_on;
    logic [5:0]  bank;
    logic [7:0]  level1 [int];
    logic [7:0]  level2 [int];
    port_reply_t pending_replies [$];
    int          failures;

    function void reset_state();
      version = 3'd3;
      as_is   = 1'b0;
      glyph   = '0;
      ram_on  = 1'b0;
      rom_on  = 1'b0;
      bank    = '0;
    endfunction

    function void set_register(input logic idx, input logic [2:0] value);
      if (idx == CFG_MACHINE_VERSION) version = value;
      else as_is = value[0];
    endfunction

    function bit is_loaded(input logic [1:0] src, input logic [ROM_AW-1:0] where);
      if (src == SRC_L1) return level1.exists(int'(where));
      if (src == SRC_L2) return level2.exists(int'(where));
      return 1'b1;
    endfunction

    // Old-machine view of a level-1 offset: bitmap glyphs read 00/01, swapped ones come from L2
    function void legacy_source(input logic [ROM_AW-1:0] off, output logic [1:0] src,
                                output logic [ROM_AW-1:0] where, output logic [7:0] value);
      logic [ROM_AW-1:0] base;
      src   = SRC_L1;
      where = off;
      value = 8'h00;
      if (off < LEGACY_LOW_END && off[16:10] < UNDEF_WORDS && UNDEF_MAP[off[14:10]][off[9:5]]) begin
        src   = SRC_CONST;
        value = {7'b0, off[0]};
        return;
      end
      for (int k = 0; k < SWAP_COUNT; k++) begin
        base = {SWAP_GLYPH[k], 1'b0};
        if (off >= base && off < base + 32) begin
          src   = SRC_L2;
          where = {SWAP_SRC[k], 1'b0} + (off - base);
          return;
        end
      end
    endfunction

    // Where a bus read gets its byte from: a constant, or a ROM byte
    function void locate_byte(input logic [15:0] addr, input logic sub, output logic hit,
                              output logic [1:0] src, output logic [ROM_AW-1:0] where,
                              output logic [7:0] value);
      logic [ROM_AW-1:0] off;
      off   = {glyph, addr[0]};
      hit   = 1'b1;
      src   = SRC_CONST;
      where = off;
      value = 8'hff;
      case (addr)
        PORT_ADDR_HI, PORT_ADDR_LO, PORT_ADDR2_HI, PORT_ADDR2_LO: ;
        PORT_L1_EVEN, PORT_L1_ODD: begin
          if (!sub) begin
            if (version <= 2 && off < LEGACY_LOW_END && !as_is)
              legacy_source(off, src, where, value);
            else if (version <= 1 && off < UNDEF_END && !as_is)
              value = {7'b0, addr[0]};
            else if (version >= 3 || as_is)
              src = SRC_L1;
            else
              legacy_source(off, src, where, value);
          end
        end
        PORT_L2_EVEN, PORT_L2_ODD: begin
          if (version >= 3 && !sub) src = SRC_L2;
        end
        default: begin
          hit   = 1'b0;
          value = 8'h00;
        end
      endcase
    endfunction

    // Update the state for one accepted transaction and queue its reply
    function void note_transaction(input logic [1:0] act, input logic [15:0] addr,
                                   input logic [7:0] data, input logic sel,
                                   input logic [ROM_AW-1:0] boff, input logic sub);
      port_reply_t       r;
      logic              hit;
      logic [1:0]        src;
      logic [ROM_AW-1:0] where;
      logic [7:0]        value;
      logic              newer;
      r = '0;
      newer = version >= 3;
      case (act)
        ACT_READ: begin
          locate_byte(addr, sub, hit, src, where, value);
          r.handled = hit;
          if (src == SRC_L1)
            r.read_data = level1.exists(int'(where)) ? level1[int'(where)] : 8'h00;
          else if (src == SRC_L2)
            r.read_data = level2.exists(int'(where)) ? level2[int'(where)] : 8'h00;
          else
            r.read_data = value;
        end
        ACT_WRITE: begin
          r.handled = 1'b1;
          case (addr)
            PORT_ADDR2_HI: if (newer) glyph[15:8] = data;
            PORT_ADDR_HI:  glyph[15:8] = data;
            PORT_ADDR2_LO: if (newer) glyph[7:0] = data;
            PORT_ADDR_LO:  glyph[7:0] = data;
            PORT_L1_EVEN, PORT_L1_ODD, PORT_L2_ODD: ;
            PORT_L2_EVEN: begin
              if (newer) begin
                ram_on = data[7];
                rom_on = data[6];
                bank   = data[5:0];
              end
            end
            default: r.handled = 1'b0;
          endcase
        end
        ACT_LOAD: begin
          if (sel) level2[int'(boff)] = data;
          else level1[int'(boff)] = data;
        end
        default: ;
      endcase
      r.ram_en = ram_on;
      r.rom_en = rom_on;
      r.bank   = bank;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(input port_reply_t got);
      port_reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: read_data %0h handled %0b", got.read_data, got.handled);
        failures++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %0h, got %0h", exp.read_data, got.read_data);
        failures++;
      end
      if (got.handled !== exp.handled) begin
        $error("handled: expected %0b, got %0b", exp.handled, got.handled);
        failures++;
      end
      if (got.ram_en !== exp.ram_en) begin
        $error("dict_ram_enable: expected %0b, got %0b", exp.ram_en, got.ram_en);
        failures++;
      end
      if (got.rom_en !== exp.rom_en) begin
        $error("dict_rom_enable: expected %0b, got %0b", exp.rom_en, got.rom_en);
        failures++;
      end
      if (got.bank !== exp.bank) begin
        $error("dict_rom_bank: expected %0h, got %0h", exp.bank, got.bank);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        action;
  logic [15:0]       bus_addr;
  logic [7:0]        write_data;
  logic              rom_select;
  logic [ROM_AW-1:0] rom_byte_addr;
  logic              sub_kanji_owned;
  logic              cfg_we;
  logic              cfg_index;
  logic [2:0]        cfg_data;
  logic              strobe;
  logic [7:0]        read_data;
  logic              handled;
  logic              dict_ram_enable;
  logic              dict_rom_enable;
  logic [5:0]        dict_rom_bank;

  font_port_model model = new();
  bit             start_high;
  bit             steady;
  int             cycle_count;
  int             sent;

  kanji_font_rom_port DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .bus_addr        (bus_addr),
    .write_data      (write_data),
    .rom_select      (rom_select),
    .rom_byte_addr   (rom_byte_addr),
    .sub_kanji_owned (sub_kanji_owned),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .strobe          (strobe),
    .read_data       (read_data),
    .handled         (handled),
    .dict_ram_enable (dict_ram_enable),
    .dict_rom_enable (dict_rom_enable),
    .dict_rom_bank   (dict_rom_bank)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Result monitor: results cannot be held off, so every strobe is a transaction
  always @(posedge clk) begin
    if (!rst && strobe)
      model.check_reply(port_reply_t'({read_data, handled, dict_ram_enable,
                                       dict_rom_enable, dict_rom_bank}));
  end

  task automatic lower_start();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  // Present one transaction and hold it until accepted; outside steady phases, sometimes a random idle gap afterwards
  task automatic drive_item(input logic [1:0] act, input logic [15:0] addr,
                            input logic [7:0] data, input logic sel,
                            input logic [ROM_AW-1:0] boff, input logic sub);
    action          <= act;
    bus_addr        <= addr;
    write_data      <= data;
    rom_select      <= sel;
    rom_byte_addr   <= boff;
    sub_kanji_owned <= sub;
    start           <= 1'b1;
    start_high = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.note_transaction(act, addr, data, sel, boff, sub);
    sent++;
    if (!steady && $urandom_range(99) < 15) begin
      lower_start();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Bus transaction; a read of a ROM byte not yet loaded gets that byte loaded first
  task automatic issue(input logic [1:0] act, input logic [15:0] addr,
                       input logic [7:0] data, input logic sub);
    logic              hit;
    logic [1:0]        src;
    logic [ROM_AW-1:0] where;
    logic [7:0]        value;
    if (act == ACT_READ) begin
      model.locate_byte(addr, sub, hit, src, where, value);
      if (src != SRC_CONST && !model.is_loaded(src, where))
        drive_item(ACT_LOAD, 16'($urandom), 8'($urandom), src == SRC_L2, where,
                   1'($urandom));
    end
    drive_item(act, addr, data, 1'($urandom), ROM_AW'($urandom), sub);
  endtask

  // Let every queued result come back
  task automatic drain();
    lower_start();
    @(posedge clk);
    while (model.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [2:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    model.set_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Glyph addresses spread over the low area, the undefined area, swapped glyphs and anywhere
  function automatic logic [15:0] pick_glyph();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 16'h2fff));
      1: return 16'($urandom_range(16'h3000, 16'h3fff));
      2: return SWAP_GLYPH[$urandom_range(SWAP_COUNT - 1)] + 16'($urandom_range(0, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          first;
    int          n;
    logic [15:0] g;
    logic        use2;
    logic [15:0] addr;

    start           <= 1'b0;
    action          <= ACT_READ;
    bus_addr        <= '0;
    write_data      <= '0;
    rom_select      <= 1'b0;
    rom_byte_addr   <= '0;
    sub_kanji_owned <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MACHINE_VERSION;
    cfg_data        <= '0;
    rst             <= 1'b1;
    start_high = 1'b0;
    steady     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    model.reset_state();
    @(posedge clk);

    // Directed: address port reads, top and bottom of both ROMs, bank and ignored writes
    issue(ACT_READ, PORT_ADDR_HI, 8'h00, 1'b0);
    issue(ACT_READ, PORT_ADDR_LO, 8'hff, 1'b1);
    issue(ACT_READ, PORT_ADDR2_HI, 8'h00, 1'b0);
    issue(ACT_READ, PORT_ADDR2_LO, 8'h00, 1'b0);
    issue(ACT_WRITE, PORT_ADDR_HI, 8'hff, 1'b0);
    issue(ACT_WRITE, PORT_ADDR_LO, 8'hff, 1'b0);
    issue(ACT_READ, PORT_L1_ODD, 8'h00, 1'b0);
    issue(ACT_READ, PORT_L2_ODD, 8'h00, 1'b0);
    issue(ACT_WRITE, PORT_ADDR2_HI, 8'h00, 1'b0);
    issue(ACT_WRITE, PORT_ADDR2_LO, 8'h00, 1'b0);
    drive_item(ACT_LOAD, 16'h0000, 8'hff, 1'b0, '0, 1'b1);
    drive_item(ACT_LOAD, 16'hffff, 8'h00, 1'b1, '0, 1'b0);
    issue(ACT_READ, PORT_L1_EVEN, 8'h00, 1'b0);
    issue(ACT_READ, PORT_L2_EVEN, 8'h00, 1'b0);
    issue(ACT_READ, PORT_L1_EVEN, 8'h00, 1'b1);
    issue(ACT_READ, PORT_L2_EVEN, 8'h00, 1'b1);
    issue(ACT_WRITE, PORT_L2_EVEN, 8'hff, 1'b0);
    issue(ACT_WRITE, PORT_L2_EVEN, 8'h00, 1'b0);
    issue(ACT_WRITE, PORT_L2_EVEN, 8'h95, 1'b0);
    issue(ACT_WRITE, PORT_L1_EVEN, 8'h5a, 1'b0);
    issue(ACT_WRITE, PORT_L1_ODD, 8'ha5, 1'b0);
    issue(ACT_WRITE, PORT_L2_ODD, 8'h3c, 1'b0);
    issue(ACT_NONE, PORT_ADDR_HI, 8'h77, 1'b0);
    issue(ACT_READ, 16'h0000, 8'h00, 1'b0);
    issue(ACT_WRITE, 16'hffff, 8'hff, 1'b1);

    // Random phases, one register setting each; every transaction sent counts
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_register(CFG_MACHINE_VERSION, PHASE_VERSION[p]);
      write_register(CFG_AS_IS_MODE, {2'b0, PHASE_AS_IS[p]});
      steady = (p == 4);
      first = sent;
      while (sent - first < PHASE_ITEMS) begin
        if ($urandom_range(99) < 55) begin
          // address set-up followed by a burst of data port reads
          g    = pick_glyph();
          use2 = 1'($urandom_range(1));
          issue(ACT_WRITE, use2 ? PORT_ADDR2_HI : PORT_ADDR_HI, g[15:8], 1'($urandom));
          issue(ACT_WRITE, use2 ? PORT_ADDR2_LO : PORT_ADDR_LO, g[7:0], 1'($urandom));
          n = $urandom_range(1, 4);
          repeat (n) issue(ACT_READ, DATA_PORTS[$urandom_range(3)], 8'($urandom),
                           $urandom_range(9) == 0);
        end else begin
          // noise
          case ($urandom_range(5))
            0: issue(ACT_READ, 16'($urandom), 8'($urandom), 1'($urandom));
            1: issue(ACT_READ, PORT_ADDR_HI + 16'($urandom_range(15)), 8'($urandom),
                     1'($urandom));
            2: begin
              addr = ($urandom_range(2) == 0) ? PORT_L2_EVEN
                                              : PORT_ADDR_HI + 16'($urandom_range(15));
              issue(ACT_WRITE, addr, 8'($urandom), 1'($urandom));
            end
            3: issue(ACT_WRITE, 16'($urandom), 8'($urandom), 1'($urandom));
            4: drive_item(ACT_LOAD, 16'($urandom), 8'($urandom), 1'($urandom),
                          ROM_AW'($urandom), 1'($urandom));
            default: issue(ACT_NONE, PORT_ADDR_HI + 16'($urandom_range(15)), 8'($urandom),
                           1'($urandom));
          endcase
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (model.failures == 0 && model.pending_replies.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kfrp_pkg.sv
rtl/kfrp_ram.sv
rtl/kfrp_legacy.sv
rtl/kanji_font_rom_port.sv
tb/sv/testbench.sv
